[hw/rtl/fsc_pkg.sv]
// ============================================================================
// fsc_pkg
// Shared constants for the frustum sphere cull core and its multiplier.
// ============================================================================
package fsc_pkg;

    // default widths of the Q-format coordinates
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // limb width of the pipelined wide multiplier
    localparam int LIMB_W = 32;

    // configuration register file
    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 64;
    localparam int HALF_W     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 4;

    // frustum geometry
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NUM_COLS   = 4;

    // pipeline depth from request to result strobe
    localparam int PIPE_LAT = 8;

    // identity matrix in Q16.16 after reset
    localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

[hw/rtl/fsc_mul.sv]
// ============================================================================
// fsc_mul
// Unsigned wide multiplier cut into limb products over three register stages.
// ============================================================================
module fsc_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic               clk,
    input  logic [WA-1:0]      a,
    input  logic [WB-1:0]      b,
    output logic [WA+WB-1:0]   p
);

    localparam int LW    = fsc_pkg::LIMB_W;
    localparam int NA    = (WA + LW - 1) / LW;
    localparam int NB    = (WB + LW - 1) / LW;
    localparam int ROW_W = (NB + 1) * LW;
    localparam int SUM_W = (NA + NB) * LW;

    logic [NA*LW-1:0]  a_pad;
    logic [NB*LW-1:0]  b_pad;
    logic [2*LW-1:0]   pp_reg  [NA][NB];
    logic [ROW_W-1:0]  row_next [NA];
    logic [ROW_W-1:0]  row_reg  [NA];
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;

    assign a_pad = (NA*LW)'(a);
    assign b_pad = (NB*LW)'(b);

    // limb partial products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= a_pad[i*LW +: LW] * b_pad[j*LW +: LW];
            end
        end
    end

    // one row per limb of a
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (j*LW));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_reg[i] <= row_next[i];
        end
    end

    // final sum of the rows
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (SUM_W'(row_reg[i]) << (i*LW));
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign p = sum_reg[WA+WB-1:0];

endmodule

[hw/rtl/frustum_sphere_cull_core.sv]
// ============================================================================
// frustum_sphere_cull_core
// Sphere against view frustum test, planes taken from a 4x4 matrix.
// ============================================================================
// done strobes once for each accepted request; its valid bit runs through vld_reg
// throughput: one request per cycle; busy is always low
// the depth is set by the three-stage limb multipliers for the exact squares
// reset: valid pipeline cleared, matrix returns to identity
// the receiver cannot stall: visible is shown with done for one cycle
module frustum_sphere_cull_core #(
    parameter int COORD_BITS = fsc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = fsc_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsc_pkg::REG_W-1:0]     cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   center_x,
    input  logic [31:0]                   center_y,
    input  logic [31:0]                   center_z,
    input  logic [30:0]                   sphere_radius,
    output logic                          done,
    output logic                          visible
);

    localparam int C     = COORD_BITS;
    localparam int PW    = C + 1;
    localparam int PRW   = 2*C + 1;
    localparam int OFFW  = PW + FRAC_BITS;
    localparam int DW    = ((PRW > OFFW) ? PRW : OFFW) + 2;
    localparam int RW    = C - 1;
    localparam int R2W   = 2*RW;
    localparam int N2W   = 2*PW;
    localparam int LHW   = 2*DW;
    localparam int RHW   = R2W + N2W;
    localparam int CMPW  = (LHW > RHW) ? LHW : RHW;
    localparam int NP    = fsc_pkg::NUM_PLANES;
    localparam int NCOL  = fsc_pkg::NUM_COLS;
    localparam int LAT   = fsc_pkg::PIPE_LAT;

    // configuration and plane state
    logic [fsc_pkg::REG_W-1:0] mat_reg [fsc_pkg::NUM_REGS];
    logic signed [C-1:0]       entry   [4][NCOL];
    logic signed [PW-1:0]      plane_reg [NP][NCOL];
    logic signed [N2W-1:0]     sq_reg  [NP][3];
    logic [N2W-1:0]            n2_reg  [NP];
    logic [NP-1:0]             nz_reg;

    // item pipeline
    logic [LAT-1:0]            vld_reg;
    logic signed [C-1:0]       cx_reg, cy_reg, cz_reg;
    logic [RW-1:0]             rad_reg;
    logic signed [PRW-1:0]     prod_reg [NP][3];
    logic signed [DW-1:0]      off_reg  [NP];
    logic [R2W-1:0]            r2_reg, r2_d3_reg, r2_d4_reg;
    logic signed [DW-1:0]      dist_reg [NP];
    logic [DW-1:0]             mag_reg  [NP];
    logic [NP-1:0]             neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    logic [LHW-1:0]            lhs      [NP];
    logic [RHW-1:0]            rhs      [NP];
    logic [NP-1:0]             reject;
    logic                      visible_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsc_pkg::NUM_REGS; i++)
            begin
                mat_reg[i] <= fsc_pkg::MAT_RESET[i];
            end
        end
        else if (cfg_wr_en && (cfg_index < fsc_pkg::CFG_IDX_W'(fsc_pkg::NUM_REGS)))
        begin
            mat_reg[cfg_index[fsc_pkg::REG_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // matrix entries, low bits of each half
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < NCOL; k++)
            begin
                entry[r][k] = mat_reg[r*2 + k/2][(k%2)*fsc_pkg::HALF_W +: C];
            end
        end
    end

    // planes, their squared normals and the zero-normal flag
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < fsc_pkg::NUM_AXES; a++)
        begin
            for (int k = 0; k < NCOL; k++)
            begin
                plane_reg[2*a][k]   <= PW'(entry[3][k]) + PW'(entry[a][k]);
                plane_reg[2*a+1][k] <= PW'(entry[3][k]) - PW'(entry[a][k]);
            end
        end
        for (int pl = 0; pl < NP; pl++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[pl][k] <= plane_reg[pl][k] * plane_reg[pl][k];
            end
            n2_reg[pl] <= N2W'(sq_reg[pl][0]) + N2W'(sq_reg[pl][1]) + N2W'(sq_reg[pl][2]);
            nz_reg[pl] <= (sq_reg[pl][0] != '0) || (sq_reg[pl][1] != '0)
                          || (sq_reg[pl][2] != '0);
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start && !busy};
        end
    end

    // stages 1 to 4: capture, products, distance, magnitude
    always_ff @(posedge clk)
    begin
        cx_reg  <= center_x[C-1:0];
        cy_reg  <= center_y[C-1:0];
        cz_reg  <= center_z[C-1:0];
        rad_reg <= sphere_radius[RW-1:0];

        r2_reg  <= rad_reg * rad_reg;
        for (int pl = 0; pl < NP; pl++)
        begin
            prod_reg[pl][0] <= plane_reg[pl][0] * cx_reg;
            prod_reg[pl][1] <= plane_reg[pl][1] * cy_reg;
            prod_reg[pl][2] <= plane_reg[pl][2] * cz_reg;
            off_reg[pl]     <= DW'(plane_reg[pl][3]) <<< FRAC_BITS;
        end

        r2_d3_reg <= r2_reg;
        for (int pl = 0; pl < NP; pl++)
        begin
            dist_reg[pl] <= DW'(prod_reg[pl][0]) + DW'(prod_reg[pl][1])
                            + DW'(prod_reg[pl][2]) + off_reg[pl];
        end

        r2_d4_reg <= r2_d3_reg;
        for (int pl = 0; pl < NP; pl++)
        begin
            mag_reg[pl]  <= -dist_reg[pl];
            neg4_reg[pl] <= dist_reg[pl][DW-1];
        end

        neg5_reg <= neg4_reg;
        neg6_reg <= neg5_reg;
        neg7_reg <= neg6_reg;
    end

    // stages 5 to 7: exact squares per plane
    for (genvar pl = 0; pl < NP; pl++)
    begin : g_plane
        fsc_mul #(.WA(DW), .WB(DW)) u_lhs_mul (
            .clk (clk),
            .a   (mag_reg[pl]),
            .b   (mag_reg[pl]),
            .p   (lhs[pl])
        );

        fsc_mul #(.WA(R2W), .WB(N2W)) u_rhs_mul (
            .clk (clk),
            .a   (r2_d4_reg),
            .b   (n2_reg[pl]),
            .p   (rhs[pl])
        );

        assign reject[pl] = neg7_reg[pl] && nz_reg[pl]
                            && (CMPW'(lhs[pl]) > CMPW'(rhs[pl]));
    end

    // stage 8: combine the six planes
    always_ff @(posedge clk)
    begin
        visible_reg <= ~|reject;
    end

    assign busy    = 1'b0;
    assign done    = vld_reg[LAT-1];
    assign visible = visible_reg;

    // every request gives exactly one result after the pipeline depth
    a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##8 done)
        else $error("request without result");

    a_done_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 8))
        else $error("result without request");

    a_rej_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (reject != '0) |-> ((neg7_reg & nz_reg) != '0))
        else $error("plane rejects with non-negative distance or zero normal");

endmodule
